// ===== rtl/sed_pkg.sv =====
// sed_pkg: shared types, character codes and helpers for the string escape decoder
// no dependencies; imported by every module of the block except sed_checker
`default_nettype none

package sed_pkg;

  typedef enum logic [2:0] {
    MODE_PLAIN = 3'd0,
    MODE_ESC   = 3'd1,
    MODE_ZERO  = 3'd2,
    MODE_HEX   = 3'd3,
    MODE_DEC   = 3'd4
  } mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic       bad;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [1:0] cnt;
    item_t      r0;
    item_t      r1;
  } step_t;

  localparam int unsigned OUTQ_DEPTH = 4;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_X_LO   = 8'h78;
  localparam logic [7:0] CH_X_UP   = 8'h58;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_1      = 8'h31;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_A_LO   = 8'h61;
  localparam logic [7:0] CH_F_LO   = 8'h66;
  localparam logic [7:0] CH_A_UP   = 8'h41;
  localparam logic [7:0] CH_F_UP   = 8'h46;

  localparam logic [7:0] CODE_LF  = 8'h0a;
  localparam logic [7:0] CODE_TAB = 8'h09;
  localparam logic [7:0] CODE_BS  = 8'h08;
  localparam logic [7:0] CODE_CR  = 8'h0d;
  localparam logic [7:0] CODE_FF  = 8'h0c;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || ((c >= CH_A_LO) && (c <= CH_F_LO)) ||
           ((c >= CH_A_UP) && (c <= CH_F_UP));
  endfunction

  // letters a-f and A-F share their low three bits: 1..6 maps to 10..15
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    if (is_dec(c)) begin
      v = c[3:0];
    end else begin
      v = {1'b0, c[2:0]} + 4'd9;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sed_decode.sv =====
// sed_decode: escape state machine and numeric accumulator, one byte per request
// depends on sed_pkg; gives up to two result items per byte as a step_t
`default_nettype none

module sed_decode (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     byte_i,
  output sed_pkg::step_t step_o
);
  import sed_pkg::*;

  mode_e      mode_q, mode_d;
  logic [7:0] acc_q, acc_d;
  item_t      p_item;
  logic       p_emit;
  mode_e      p_mode;
  item_t      acc_item;
  item_t      zero_item;
  logic [7:0] acc_x10;

  // plain-text handling of the current byte
  assign p_item    = '{data: byte_i, bad: 1'b0, last: (byte_i == CH_NUL)};
  assign p_emit    = (byte_i != CH_BSLASH);
  assign p_mode    = (byte_i == CH_BSLASH) ? MODE_ESC : MODE_PLAIN;
  assign acc_item  = '{data: acc_q, bad: 1'b0, last: 1'b0};
  assign zero_item = '{data: 8'h00, bad: 1'b0, last: 1'b0};
  assign acc_x10   = 8'({acc_q, 3'b000} + {acc_q, 1'b0});

  // next state
  always_comb begin
    mode_d = mode_q;
    acc_d  = acc_q;
    case (mode_q)
      MODE_ESC: begin
        mode_d = MODE_PLAIN;
        if (byte_i == CH_NUL) begin
          acc_d = 8'h00;
        end else if (byte_i == CH_0) begin
          mode_d = MODE_ZERO;
          acc_d  = 8'h00;
        end else if ((byte_i >= CH_1) && (byte_i <= CH_9)) begin
          mode_d = MODE_DEC;
          acc_d  = {4'h0, byte_i[3:0]};
        end
      end
      MODE_ZERO: begin
        if ((byte_i == CH_X_LO) || (byte_i == CH_X_UP)) begin
          mode_d = MODE_HEX;
        end else begin
          mode_d = p_mode;
        end
        acc_d = 8'h00;
      end
      MODE_HEX: begin
        if (is_hex(byte_i)) begin
          acc_d = {acc_q[3:0], hex_val(byte_i)};
        end else begin
          mode_d = p_mode;
          acc_d  = 8'h00;
        end
      end
      MODE_DEC: begin
        if (is_dec(byte_i)) begin
          acc_d = 8'(acc_x10 + {4'h0, byte_i[3:0]});
        end else begin
          mode_d = p_mode;
          acc_d  = 8'h00;
        end
      end
      default: begin
        mode_d = p_mode;
        if (byte_i == CH_NUL) begin
          acc_d = 8'h00;
        end
      end
    endcase
  end

  // result items
  always_comb begin
    step_o = '0;
    case (mode_q)
      MODE_ESC: begin
        step_o.cnt = 2'd1;
        case (byte_i)
          CH_NUL:    step_o.r0 = '{data: 8'h00, bad: 1'b0, last: 1'b1};
          CH_N:      step_o.r0 = '{data: CODE_LF, bad: 1'b0, last: 1'b0};
          CH_T:      step_o.r0 = '{data: CODE_TAB, bad: 1'b0, last: 1'b0};
          CH_B:      step_o.r0 = '{data: CODE_BS, bad: 1'b0, last: 1'b0};
          CH_R:      step_o.r0 = '{data: CODE_CR, bad: 1'b0, last: 1'b0};
          CH_F:      step_o.r0 = '{data: CODE_FF, bad: 1'b0, last: 1'b0};
          CH_BSLASH: step_o.r0 = '{data: CH_BSLASH, bad: 1'b0, last: 1'b0};
          CH_QUOTE:  step_o.r0 = '{data: CH_QUOTE, bad: 1'b0, last: 1'b0};
          default: begin
            if (is_dec(byte_i)) begin
              step_o.cnt = 2'd0;
            end else begin
              step_o.r0 = '{data: 8'h00, bad: 1'b1, last: 1'b0};
            end
          end
        endcase
      end
      MODE_ZERO: begin
        if ((byte_i != CH_X_LO) && (byte_i != CH_X_UP)) begin
          step_o.r0  = zero_item;
          step_o.r1  = p_item;
          step_o.cnt = p_emit ? 2'd2 : 2'd1;
        end
      end
      MODE_HEX: begin
        if (!is_hex(byte_i)) begin
          step_o.r0  = acc_item;
          step_o.r1  = p_item;
          step_o.cnt = p_emit ? 2'd2 : 2'd1;
        end
      end
      MODE_DEC: begin
        if (!is_dec(byte_i)) begin
          step_o.r0  = acc_item;
          step_o.r1  = p_item;
          step_o.cnt = p_emit ? 2'd2 : 2'd1;
        end
      end
      default: begin
        step_o.r0  = p_item;
        step_o.cnt = {1'b0, p_emit};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PLAIN;
      acc_q  <= 8'h00;
    end else if (accept_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sed_outq.sv =====
// sed_outq: small result queue taking up to two items per cycle, one out per cycle
// depends on sed_pkg for item_t and step_t
`default_nettype none

module sed_outq #(
  parameter int unsigned Depth = sed_pkg::OUTQ_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sed_pkg::step_t step_i,
  input  logic           pop_i,
  output logic           valid_o,
  output logic           full_o,
  output sed_pkg::item_t head_o
);
  import sed_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, wr1, rd_q, rd_d;
  logic [CntW-1:0] count_q, count_d;
  logic [1:0]      n_push;
  logic            do_pop;

  function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : PtrW'(p + 1'b1);
  endfunction

  assign n_push  = push_i ? step_i.cnt : 2'd0;
  assign do_pop  = pop_i && valid_o;
  assign wr1     = inc(wr_q);
  assign wr_d    = (n_push == 2'd2) ? inc(wr1) : ((n_push == 2'd1) ? wr1 : wr_q);
  assign rd_d    = do_pop ? inc(rd_q) : rd_q;
  assign count_d = CntW'(count_q + CntW'(n_push) - CntW'(do_pop));

  assign valid_o = (count_q != '0);
  // room for two items is needed before a new request is taken
  assign full_o  = (count_q > CntW'(Depth - 2));
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_q] <= step_i.r0;
    end
    if (n_push == 2'd2) begin
      mem_q[wr1] <= step_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/string_escape_decoder_unit.sv =====
// string escape decoder: one source byte per cycle in while in_stall_o is low, decoded bytes out.
// a decoded byte is written to the result queue and shows once earlier results have left.
// throughput: one byte per cycle while in_stall_o is low; a byte that closes a number can give
// two results, which leave one at a time and are absorbed by the OutqDepth-entry result queue.
// reset: mode returns to plain text, accumulator to zero, result queue empties.
// depends on sed_pkg, sed_decode and sed_outq
`default_nettype none

module string_escape_decoder_unit #(
  parameter int unsigned OutqDepth = sed_pkg::OUTQ_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       bad_escape_o,
  output logic       is_last_o
);
  import sed_pkg::*;

  logic  accept;
  logic  q_full;
  step_t step;
  item_t head;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  sed_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (in_byte_i),
    .step_o   (step)
  );

  sed_outq #(
    .Depth (OutqDepth)
  ) u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .step_i  (step),
    .pop_i   (!out_stall_i),
    .valid_o (out_valid_o),
    .full_o  (q_full),
    .head_o  (head)
  );

  assign out_byte_o   = head.data;
  assign bad_escape_o = head.bad;
  assign is_last_o    = head.last;

endmodule

`default_nettype wire

// ===== rtl/sed_checker.sv =====
// sed_checker: port-level assertions for string_escape_decoder_unit
// bound to the top level below; no package dependency
`default_nettype none

module sed_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] in_byte_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       bad_escape_o,
  input logic       is_last_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) &&
    $stable(bad_escape_o) && $stable(is_last_o))
    else $error("stalled result changed");

  // terminator is a clean zero
  a_last_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_last_o |-> out_byte_o == 8'h00 && !bad_escape_o)
    else $error("terminator not zero");

  // unknown escape gives zero
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_escape_o |-> out_byte_o == 8'h00)
    else $error("flagged escape not zero");

  // input side only stalls while results are queued
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("stall with empty result queue");

  // a terminator byte taken while the result queue is empty gives a result next cycle
  a_idle_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o && in_byte_i == 8'h00 |=> out_valid_o)
    else $error("terminator request produced no result");

endmodule

bind string_escape_decoder_unit sed_checker u_sed_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .in_byte_i    (in_byte_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_byte_o   (out_byte_o),
  .bad_escape_o (bad_escape_o),
  .is_last_o    (is_last_o)
);

`default_nettype wire
